// File: rtl/pbseq_pkg.sv
// shared types, codes and constants of the playback sequencer
package pbseq_pkg;

    localparam int MAX_SONGS    = 64;
    localparam int VOLUME_MAX   = 254;
    localparam int LED_PERIOD   = 50;
    localparam int VOLUME_RESET = 40;

    localparam int OPCODE_W = 2;
    localparam int BUTTON_W = 4;
    localparam int POS_W    = 32;
    localparam int SONG_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int VOL_W    = 8;
    localparam int SKIP_W   = 24;
    localparam int LED_W    = 6;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_PRE   = 3'd1,
        ST_PLAY  = 3'd2,
        ST_PAUSE = 3'd3,
        ST_POST  = 3'd4
    } play_state_t;

    localparam logic [OPCODE_W-1:0] OP_STEP = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_EOD  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LED  = 2'd2;

    localparam logic [BUTTON_W-1:0] BTN_NONE      = 4'd0;
    localparam logic [BUTTON_W-1:0] BTN_PP        = 4'd1;
    localparam logic [BUTTON_W-1:0] BTN_PP_LONG   = 4'd2;
    localparam logic [BUTTON_W-1:0] BTN_UP        = 4'd3;
    localparam logic [BUTTON_W-1:0] BTN_DOWN      = 4'd4;
    localparam logic [BUTTON_W-1:0] BTN_NEXT      = 4'd5;
    localparam logic [BUTTON_W-1:0] BTN_PREV      = 4'd6;
    localparam logic [BUTTON_W-1:0] BTN_NEXT_LONG = 4'd7;
    localparam logic [BUTTON_W-1:0] BTN_PREV_LONG = 4'd8;

    localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPEAT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SONG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_BYTES  = 2'd3;

endpackage

// File: rtl/playback_sequencer.sv
// playback sequencer top level: event register, state update and result register
//
// Takes one player event per transaction on the s_ side and returns exactly one result
// per event on the m_ side, in order. An event sits in the input register while the
// state-update logic works on it. When the result side has room, the playback state and
// the result register are written together. A new event can be taken every cycle while
// the result side keeps up (one event per cycle sustained). The input register keeps
// accepting while a finished result waits to be taken; only when both the result and
// the input register are full does s_tready drop. Configuration writes are taken on
// the cfg_ channel at any time (cfg_ready is always high) and must only be issued while
// no event is in flight.
module playback_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbseq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pbseq_pkg::SKIP_W-1:0]    cfg_data,
    // event stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // button[3:0], open_ok[4], file_position[36:5], file_size[68:37],
    // random_index[74:69], zero fill[79:75]
    input  logic [pbseq_pkg::IN_DATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [pbseq_pkg::OPCODE_W-1:0]  s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // play_state[2:0], song_index[8:3], volume_level[16:9], led_on[17],
    // open_request[18], close_request[19], seek_valid[20], seek_position[52:21],
    // zero fill[55:53]
    output logic [pbseq_pkg::OUT_DATA_W-1:0] m_tdata
);
    import pbseq_pkg::*;

    // configuration registers
    logic [MODE_W-1:0]  play_mode_reg;
    logic [COUNT_W-1:0] song_count_reg;
    logic [VOL_W-1:0]   volume_step_reg;
    logic [SKIP_W-1:0]  skip_bytes_reg;

    // input register
    logic                in_valid_reg;
    logic [OPCODE_W-1:0] in_opcode_reg;
    logic [BUTTON_W-1:0] in_button_reg;
    logic                in_open_ok_reg;
    logic [POS_W-1:0]    in_pos_reg;
    logic [POS_W-1:0]    in_size_reg;
    logic [SONG_W-1:0]   in_rnd_reg;

    // playback state
    play_state_t         state_reg, state_next;
    logic [BUTTON_W-1:0] pend_reg, pend_next;
    logic [SONG_W-1:0]   song_reg, song_next;
    logic [VOL_W-1:0]    vol_reg, vol_next;
    logic [LED_W-1:0]    led_cnt_reg, led_cnt_next;
    logic                led_toggle_reg, led_toggle_next;
    logic                led_reg, led_next;

    // result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic advance;
    logic fire;

    // per-event combinational results
    logic                open_req, close_req, seek_ok;
    logic [POS_W-1:0]    seek_pos;
    logic [BUTTON_W-1:0] btn;
    logic [COUNT_W-1:0]  eff_n;
    logic [COUNT_W-1:0]  last_idx;
    logic [COUNT_W-1:0]  song_ext;
    logic [COUNT_W-1:0]  song_inc;
    logic [SONG_W-1:0]   next_wrap;
    logic [SONG_W-1:0]   prev_wrap;
    logic [SONG_W-1:0]   rnd_pick;
    logic                at_end;
    logic [VOL_W:0]      vol_sum;
    logic [POS_W:0]      fwd_sum;

    assign cfg_ready = 1'b1;

    // result side frees a slot when empty or taken this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_mode_reg   <= MODE_NORMAL;
            song_count_reg  <= '0;
            volume_step_reg <= VOL_W'(1);
            skip_bytes_reg  <= SKIP_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PLAY_MODE:   play_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_SONG_COUNT:  song_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_VOLUME_STEP: volume_step_reg <= cfg_data[VOL_W-1:0];
                REG_SKIP_BYTES:  skip_bytes_reg  <= cfg_data;
                default:         play_mode_reg   <= play_mode_reg;
            endcase
        end
    end

    // input register: valid bit resets, payload does not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_opcode_reg  <= s_tuser;
            in_button_reg  <= s_tdata[3:0];
            in_open_ok_reg <= s_tdata[4];
            in_pos_reg     <= s_tdata[36:5];
            in_size_reg    <= s_tdata[68:37];
            in_rnd_reg     <= s_tdata[74:69];
        end
    end

    // playlist helpers: out-of-range songs count as the last one
    always_comb
    begin
        eff_n    = (song_count_reg > COUNT_W'(MAX_SONGS)) ? COUNT_W'(MAX_SONGS)
                                                          : song_count_reg;
        last_idx = eff_n - COUNT_W'(1);
        song_ext = {1'b0, song_reg};
        song_inc = song_ext + COUNT_W'(1);
        at_end   = (eff_n == '0) || (song_inc >= eff_n);
        next_wrap = at_end ? '0 : song_inc[SONG_W-1:0];
        if (eff_n == '0)
        begin
            prev_wrap = '0;
        end
        else if ((song_reg == '0) || (song_ext >= eff_n))
        begin
            prev_wrap = last_idx[SONG_W-1:0];
        end
        else
        begin
            prev_wrap = song_reg - SONG_W'(1);
        end
        if (eff_n == '0)
        begin
            rnd_pick = '0;
        end
        else if ({1'b0, in_rnd_reg} >= eff_n)
        begin
            rnd_pick = last_idx[SONG_W-1:0];
        end
        else
        begin
            rnd_pick = in_rnd_reg;
        end
        vol_sum = {1'b0, vol_reg} + {1'b0, volume_step_reg};
        fwd_sum = {1'b0, in_pos_reg} + {{(POS_W+1-SKIP_W){1'b0}}, skip_bytes_reg};
    end

    // event processing
    always_comb
    begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        song_next       = song_reg;
        vol_next        = vol_reg;
        led_cnt_next    = led_cnt_reg;
        led_toggle_next = led_toggle_reg;
        led_next        = led_reg;
        open_req        = 1'b0;
        close_req       = 1'b0;
        seek_ok         = 1'b0;
        seek_pos        = '0;
        // a pressed button replaces the latched one
        btn = ((in_button_reg >= BTN_PP) && (in_button_reg <= BTN_PREV_LONG))
              ? in_button_reg : pend_reg;

        case (in_opcode_reg)
            OP_STEP:
            begin
                pend_next = btn;
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (btn == BTN_PP)
                        begin
                            state_next = ST_PRE;
                            pend_next  = BTN_NONE;
                        end
                        close_req = 1'b1;
                    end
                    ST_PRE:
                    begin
                        if (eff_n == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            open_req   = 1'b1;
                            close_req  = 1'b1;
                            state_next = in_open_ok_reg ? ST_PLAY : ST_POST;
                        end
                    end
                    ST_PLAY:
                    begin
                        pend_next = BTN_NONE;
                        case (btn)
                            BTN_PP:      state_next = ST_PAUSE;
                            BTN_PP_LONG: state_next = ST_IDLE;
                            BTN_UP:
                            begin
                                vol_next = (vol_sum > (VOL_W+1)'(VOLUME_MAX))
                                           ? VOL_W'(VOLUME_MAX) : vol_sum[VOL_W-1:0];
                            end
                            BTN_DOWN:
                            begin
                                vol_next = (vol_reg < volume_step_reg)
                                           ? '0 : vol_reg - volume_step_reg;
                            end
                            BTN_NEXT, BTN_PREV:
                            begin
                                if (play_mode_reg == MODE_SHUFFLE)
                                begin
                                    song_next = rnd_pick;
                                end
                                else if (btn == BTN_NEXT)
                                begin
                                    song_next = next_wrap;
                                end
                                else
                                begin
                                    song_next = prev_wrap;
                                end
                                close_req  = 1'b1;
                                state_next = ST_PRE;
                            end
                            BTN_NEXT_LONG:
                            begin
                                if (fwd_sum < {1'b0, in_size_reg})
                                begin
                                    seek_ok  = 1'b1;
                                    seek_pos = fwd_sum[POS_W-1:0];
                                end
                            end
                            BTN_PREV_LONG:
                            begin
                                if (in_pos_reg > POS_W'(skip_bytes_reg))
                                begin
                                    seek_ok  = 1'b1;
                                    seek_pos = in_pos_reg - POS_W'(skip_bytes_reg);
                                end
                            end
                            default: pend_next = BTN_NONE;
                        endcase
                    end
                    ST_PAUSE:
                    begin
                        if (btn == BTN_PP)
                        begin
                            state_next = ST_PLAY;
                            pend_next  = BTN_NONE;
                        end
                    end
                    default:
                    begin
                        // post-play: pick what comes after the finished song
                        close_req  = 1'b1;
                        state_next = ST_PRE;
                        if (play_mode_reg == MODE_SHUFFLE)
                        begin
                            song_next = rnd_pick;
                        end
                        else if (play_mode_reg == MODE_NORMAL)
                        begin
                            if (at_end)
                            begin
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                song_next = song_inc[SONG_W-1:0];
                            end
                        end
                        else if (play_mode_reg == MODE_REPEAT)
                        begin
                            song_next = next_wrap;
                        end
                    end
                endcase
            end
            OP_EOD:
            begin
                if (state_reg == ST_PLAY)
                begin
                    state_next = ST_POST;
                end
            end
            OP_LED:
            begin
                if (state_reg == ST_PAUSE)
                begin
                    led_next = 1'b1;
                end
                else if (state_reg == ST_IDLE)
                begin
                    led_next = 1'b0;
                end
                else if (led_cnt_reg <= LED_W'(1))
                begin
                    led_cnt_next    = LED_W'(LED_PERIOD);
                    led_next        = led_toggle_reg;
                    led_toggle_next = !led_toggle_reg;
                end
                else
                begin
                    led_cnt_next = led_cnt_reg - LED_W'(1);
                end
            end
            default:
            begin
                led_next = led_reg;
            end
        endcase
    end

    // playback state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_PRE;
            pend_reg       <= BTN_NONE;
            song_reg       <= '0;
            vol_reg        <= VOL_W'(VOLUME_RESET);
            led_cnt_reg    <= LED_W'(LED_PERIOD);
            led_toggle_reg <= 1'b1;
            led_reg        <= 1'b0;
        end
        else if (fire)
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            song_reg       <= song_next;
            vol_reg        <= vol_next;
            led_cnt_reg    <= led_cnt_next;
            led_toggle_reg <= led_toggle_next;
            led_reg        <= led_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {3'b000, seek_pos, seek_ok, close_req, open_req, led_next,
                             vol_next, song_next, state_next};
        end
    end

endmodule

// File: rtl/pbseq_checker.sv
// port-level checker for the playback sequencer and its bind
module pbseq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pbseq_pkg::OUT_DATA_W-1:0] m_tdata
);
    import pbseq_pkg::*;

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

    // seek target only reported with a seek
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[20]) |-> (m_tdata[52:21] == '0))
    else $error("seek position without seek");

    // a seek only happens while playing and leaves the machine in play
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[20]) |-> (m_tdata[2:0] == ST_PLAY))
    else $error("seek outside play");

    // opening a song always closes the previous one and leaves play or post-play
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[18]) |->
        (m_tdata[19] && ((m_tdata[2:0] == ST_PLAY) || (m_tdata[2:0] == ST_POST))))
    else $error("bad open request");

endmodule

bind playback_sequencer pbseq_checker u_pbseq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
